### rtl/core/i2c_slave_byte_engine_macros.svh
// ----------------------------------------------------------------------------
// I2C slave byte engine assertion macros
// Shared assertion forms for the engine's port checker.
// ----------------------------------------------------------------------------
`ifndef I2C_SLAVE_BYTE_ENGINE_MACROS_SVH
`define I2C_SLAVE_BYTE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define I2CSBE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Implication whose consequent is checked after the antecedent.
`define I2CSBE_ASSERT_LAT2(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
    else $error("%m: two-cycle response failed");

`endif

### rtl/core/i2csbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave byte engine package
// Types, codes and ring sizes shared by the engine's modules.
// ----------------------------------------------------------------------------
package i2csbe_pkg;

  localparam int RX_DEPTH = 16;
  localparam int TX_DEPTH = 16;
  localparam int RX_PW    = $clog2(RX_DEPTH);
  localparam int TX_PW    = $clog2(TX_DEPTH);

  localparam logic [7:0] BYTE_ACK     = 8'h00;
  localparam logic [7:0] BYTE_RELEASE = 8'hFF;
  localparam logic [7:0] ADDR_MASK    = 8'hFE;
  localparam logic [7:0] RW_MASK      = 8'h01;

  localparam logic [3:0] BITS_NONE = 4'd0;
  localparam logic [3:0] BITS_ONE  = 4'd1;
  localparam logic [3:0] BITS_BYTE = 4'd8;

  typedef enum logic [1:0] {
    EV_START      = 2'd0,
    EV_SHIFT_DONE = 2'd1,
    EV_HOST_READ  = 2'd2,
    EV_HOST_WRITE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ADDR    = 3'd1,
    MODE_RX_ACK  = 3'd2,
    MODE_RX_DATA = 3'd3,
    MODE_TX_DATA = 3'd4,
    MODE_TX_SEND = 3'd5,
    MODE_TX_POLL = 3'd6
  } mode_e;

  // Ring operations requested by the sequencer for one event.
  typedef struct packed {
    logic       rx_push;
    logic       rx_pop;
    logic       tx_push;
    logic       tx_pop;
    logic [7:0] wdata;
  } ring_req_t;

  // Ring status seen by the sequencer and the output side.
  typedef struct packed {
    logic       rx_empty;
    logic       tx_empty;
    logic [7:0] rx_rdata;
    logic [7:0] tx_rdata;
    logic [3:0] rx_count;
  } ring_stat_t;

  // Per-event result fields that go into the result register.
  typedef struct packed {
    logic       shift_load;
    logic [7:0] shift_byte;
    logic [7:0] host_byte;
  } seq_res_t;

endpackage

### rtl/core/i2c_slave_byte_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave byte engine
// Byte-level 7-bit I2C slave sequencer with receive and transmit rings.
// ----------------------------------------------------------------------------
// One event is taken in every clock cycle: busy stays low, so start with
// kind_i, line_sda_i and data_in_i is a transfer on every rising edge where
// start is high. Each event gives exactly one result, shown with done_o
// high for a single cycle; the event passes the input register, then the sequencer and
// ring update into the result register. The receiver cannot stall the
// result, so sample it in the done_o cycle; the mode-derived fields
// (bits_to_shift_o, drive_sda_o, bus_active_o) and rx_count_o are valid with
// done_o and follow later events afterwards. The rate is set by the sequencer's
// mode register, whose next value depends on itself, the event and own address. The
// user must write own_address through cfg_we_i / cfg_wdata_i only while no
// event is in flight; the block does not enforce it. Rings need no clearing after reset.
// ----------------------------------------------------------------------------
module i2c_slave_byte_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind_i,
  input  logic       line_sda_i,
  input  logic [7:0] data_in_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  output logic       done_o,
  output logic       shift_load_o,
  output logic [7:0] shift_byte_o,
  output logic [3:0] bits_to_shift_o,
  output logic       drive_sda_o,
  output logic       bus_active_o,
  output logic [7:0] host_byte_o,
  output logic [3:0] rx_count_o
);
  import i2csbe_pkg::*;

  logic       in_vld_q;
  kind_e      kind_q;
  logic       sda_q;
  logic [7:0] data_q;
  logic [6:0] own_address_q;
  logic       done_q;
  seq_res_t   res_q;
  seq_res_t   res_d;
  ring_req_t  ring_req;
  ring_stat_t ring_stat;

  // Never hold off an event.
  assign busy = 1'b0;

  // Own address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= '0;
    end else if (cfg_we_i) begin
      own_address_q <= cfg_wdata_i;
    end
  end

  // Input register: capture each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      kind_q <= kind_e'(kind_i);
      sda_q  <= line_sda_i;
      data_q <= data_in_i;
    end
  end

  i2csbe_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_vld_q),
    .kind_i          (kind_q),
    .sda_i           (sda_q),
    .data_i          (data_q),
    .own_address_i   (own_address_q),
    .stat_i          (ring_stat),
    .req_o           (ring_req),
    .res_o           (res_d),
    .bits_to_shift_o (bits_to_shift_o),
    .drive_sda_o     (drive_sda_o),
    .bus_active_o    (bus_active_o)
  );

  i2csbe_rings u_rings (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ring_req),
    .stat_o (ring_stat)
  );

  // Result register: strobe one result per processed event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o       = done_q;
  assign shift_load_o = res_q.shift_load;
  assign shift_byte_o = res_q.shift_byte;
  assign host_byte_o  = res_q.host_byte;
  assign rx_count_o   = ring_stat.rx_count;

endmodule

### rtl/core/i2csbe_rings.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave byte engine rings
// Receive and transmit byte rings with wrap-around positions.
// ----------------------------------------------------------------------------
module i2csbe_rings (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  i2csbe_pkg::ring_req_t  req_i,
  output i2csbe_pkg::ring_stat_t stat_o
);
  import i2csbe_pkg::*;

  localparam int RxCw = RX_PW + 1;

  logic [7:0]       rx_mem [RX_DEPTH];
  logic [7:0]       tx_mem [TX_DEPTH];
  logic [RX_PW-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d;
  logic [TX_PW-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d;
  logic [RxCw-1:0]  rx_cnt;

  // Advance each position on its operation, wrapping at the depth.
  always_comb begin
    rx_wp_d = rx_wp_q;
    rx_rp_d = rx_rp_q;
    tx_wp_d = tx_wp_q;
    tx_rp_d = tx_rp_q;
    if (req_i.rx_push) begin
      rx_wp_d = (rx_wp_q == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_wp_q + RX_PW'(1);
    end
    if (req_i.rx_pop) begin
      rx_rp_d = (rx_rp_q == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_rp_q + RX_PW'(1);
    end
    if (req_i.tx_push) begin
      tx_wp_d = (tx_wp_q == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_wp_q + TX_PW'(1);
    end
    if (req_i.tx_pop) begin
      tx_rp_d = (tx_rp_q == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_rp_q + TX_PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wp_q <= '0;
      rx_rp_q <= '0;
      tx_wp_q <= '0;
      tx_rp_q <= '0;
    end else begin
      rx_wp_q <= rx_wp_d;
      rx_rp_q <= rx_rp_d;
      tx_wp_q <= tx_wp_d;
      tx_rp_q <= tx_rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rx_push) begin
      rx_mem[rx_wp_q] <= req_i.wdata;
    end
    if (req_i.tx_push) begin
      tx_mem[tx_wp_q] <= req_i.wdata;
    end
  end

  // Waiting bytes, modulo depth.
  always_comb begin
    if (rx_wp_q >= rx_rp_q) begin
      rx_cnt = {1'b0, rx_wp_q} - {1'b0, rx_rp_q};
    end else begin
      rx_cnt = {1'b0, rx_wp_q} + RxCw'(RX_DEPTH) - {1'b0, rx_rp_q};
    end
  end

  assign stat_o.rx_empty = (rx_wp_q == rx_rp_q);
  assign stat_o.tx_empty = (tx_wp_q == tx_rp_q);
  assign stat_o.rx_rdata = rx_mem[rx_rp_q];
  assign stat_o.tx_rdata = tx_mem[tx_rp_q];
  assign stat_o.rx_count = 4'(rx_cnt);

endmodule

### rtl/core/i2csbe_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave byte engine sequencer
// Byte-level bus mode machine and host event decode.
// ----------------------------------------------------------------------------
module i2csbe_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  i2csbe_pkg::kind_e      kind_i,
  input  logic                   sda_i,
  input  logic [7:0]             data_i,
  input  logic [6:0]             own_address_i,
  input  i2csbe_pkg::ring_stat_t stat_i,
  output i2csbe_pkg::ring_req_t  req_o,
  output i2csbe_pkg::seq_res_t   res_o,
  output logic [3:0]             bits_to_shift_o,
  output logic                   drive_sda_o,
  output logic                   bus_active_o
);
  import i2csbe_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] addr;
  logic       tx_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign addr    = data_i & ADDR_MASK;
  // Take a transmit byte only when the ring has one queued; else zero is shifted.
  assign tx_take = !stat_i.tx_empty;

  always_comb begin
    mode_d         = mode_q;
    req_o          = '0;
    req_o.wdata    = data_i;
    res_o          = '0;
    if (valid_i) begin
      unique case (kind_i)
        EV_START: begin
          if (sda_i) begin
            mode_d = MODE_IDLE;
          end else begin
            mode_d           = MODE_ADDR;
            res_o.shift_load = 1'b1;
            res_o.shift_byte = BYTE_RELEASE;
          end
        end
        EV_SHIFT_DONE: begin
          unique case (mode_q)
            MODE_ADDR: begin
              res_o.shift_load = 1'b1;
              res_o.shift_byte = BYTE_ACK;
              if (addr == {own_address_i, 1'b0}) begin
                mode_d = ((data_i & RW_MASK) != 8'h00) ? MODE_TX_DATA : MODE_RX_ACK;
              end else if (addr == 8'h00) begin
                mode_d = MODE_RX_ACK;
              end else begin
                mode_d = MODE_IDLE;
              end
            end
            MODE_RX_ACK: begin
              mode_d = MODE_RX_DATA;
            end
            MODE_RX_DATA: begin
              req_o.rx_push    = 1'b1;
              mode_d           = MODE_RX_ACK;
              res_o.shift_load = 1'b1;
              res_o.shift_byte = BYTE_ACK;
            end
            MODE_TX_DATA: begin
              mode_d           = MODE_TX_SEND;
              res_o.shift_load = 1'b1;
              req_o.tx_pop     = tx_take;
              res_o.shift_byte = tx_take ? stat_i.tx_rdata : 8'h00;
            end
            MODE_TX_SEND: begin
              mode_d           = MODE_TX_POLL;
              res_o.shift_load = 1'b1;
              res_o.shift_byte = BYTE_ACK;
            end
            MODE_TX_POLL: begin
              res_o.shift_load = 1'b1;
              if (data_i == 8'h00) begin
                mode_d           = MODE_TX_SEND;
                req_o.tx_pop     = tx_take;
                res_o.shift_byte = tx_take ? stat_i.tx_rdata : 8'h00;
              end else begin
                mode_d           = MODE_IDLE;
                res_o.shift_byte = BYTE_ACK;
              end
            end
            default: begin
              mode_d = MODE_IDLE;
            end
          endcase
        end
        EV_HOST_READ: begin
          if (!stat_i.rx_empty) begin
            req_o.rx_pop    = 1'b1;
            res_o.host_byte = stat_i.rx_rdata;
          end
        end
        EV_HOST_WRITE: begin
          req_o.tx_push = 1'b1;
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  // Line-facing view of the settled mode.
  always_comb begin
    unique case (mode_q)
      MODE_ADDR:    begin bits_to_shift_o = BITS_BYTE; drive_sda_o = 1'b0; end
      MODE_RX_ACK:  begin bits_to_shift_o = BITS_ONE;  drive_sda_o = 1'b1; end
      MODE_RX_DATA: begin bits_to_shift_o = BITS_BYTE; drive_sda_o = 1'b0; end
      MODE_TX_DATA: begin bits_to_shift_o = BITS_ONE;  drive_sda_o = 1'b1; end
      MODE_TX_SEND: begin bits_to_shift_o = BITS_BYTE; drive_sda_o = 1'b1; end
      MODE_TX_POLL: begin bits_to_shift_o = BITS_ONE;  drive_sda_o = 1'b0; end
      default:      begin bits_to_shift_o = BITS_NONE; drive_sda_o = 1'b0; end
    endcase
  end

  assign bus_active_o = (mode_q != MODE_IDLE);

endmodule

### rtl/core/i2csbe_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave byte engine port checker
// Timing and consistency checks on the engine's ports, bound to the top.
// ----------------------------------------------------------------------------
`include "i2c_slave_byte_engine_macros.svh"

module i2csbe_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] kind_i,
  input logic       line_sda_i,
  input logic       done_o,
  input logic       shift_load_o,
  input logic [7:0] shift_byte_o,
  input logic [3:0] bits_to_shift_o,
  input logic       drive_sda_o,
  input logic       bus_active_o
);
  import i2csbe_pkg::*;

  logic start_evt;
  logic start_low;
  logic addr_view;
  logic quiet_view;

  assign start_evt  = start && !busy && (kind_i == EV_START);
  assign start_low  = start_evt && !line_sda_i;
  assign addr_view  = shift_load_o && (shift_byte_o == BYTE_RELEASE) &&
                      (bits_to_shift_o == BITS_BYTE) && bus_active_o;
  assign quiet_view = (bits_to_shift_o == BITS_NONE) && !drive_sda_o;

  // Every transfer produces its result through the input and result registers.
  `I2CSBE_ASSERT_LAT2(a_result_latency, clk_i, rst_ni, start && !busy, done_o)

  // A start with SDA low enters address phase and loads the release byte.
  `I2CSBE_ASSERT_LAT2(a_start_addr, clk_i, rst_ni, start_low, addr_view)

  // An idle bus neither drives SDA nor asks for bits.
  `I2CSBE_ASSERT_IMPL(a_idle_quiet, clk_i, rst_ni, done_o && !bus_active_o, quiet_view)

  // Nothing loaded means a zero shift byte.
  `I2CSBE_ASSERT_IMPL(a_noload_zero, clk_i, rst_ni, done_o && !shift_load_o, shift_byte_o == 8'h00)

endmodule

bind i2c_slave_byte_engine i2csbe_chk u_i2csbe_chk (.*);
